### rtl/core/pfe_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Postfix evaluator package
// Shared word and status types, character codes and status codes.
// ----------------------------------------------------------------------------
package pfe_pkg;

   localparam int DATA_W   = 32;
   localparam int STATUS_W = 3;
   localparam int SYMBOL_W = 8;

   typedef logic [DATA_W-1:0]   word_type;
   typedef logic [STATUS_W-1:0] status_type;
   typedef logic [SYMBOL_W-1:0] symbol_type;

   // Character codes recognized in the expression stream.
   localparam symbol_type SYM_ZERO   = 8'h30;
   localparam symbol_type SYM_PLUS   = 8'h2B;
   localparam symbol_type SYM_MINUS  = 8'h2D;
   localparam symbol_type SYM_TIMES  = 8'h2A;
   localparam symbol_type SYM_DIVIDE = 8'h2F;
   localparam symbol_type SYM_LPAREN = 8'h28;
   localparam symbol_type SYM_RPAREN = 8'h29;

   // Status codes reported with each result.
   localparam status_type ST_OK       = 3'd0;
   localparam status_type ST_FEW      = 3'd1;
   localparam status_type ST_DIVZERO  = 3'd2;
   localparam status_type ST_BADCHAR  = 3'd3;
   localparam status_type ST_MANY     = 3'd4;
   localparam status_type ST_OVERFLOW = 3'd5;

endpackage

### rtl/core/pfe_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module pfe_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Registered read port; data holds while rd_en is low.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

### rtl/core/pfe_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Signed divider
// Radix-2 restoring divider, one quotient bit per cycle, truncating toward zero.
// ----------------------------------------------------------------------------
module pfe_div (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  pfe_pkg::word_type dividend,
   input  pfe_pkg::word_type divisor,
   output logic              done,
   output pfe_pkg::word_type quotient
);

   import pfe_pkg::*;

   localparam int STEP_W = $clog2(DATA_W + 1);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [STEP_W-1:0] step_ff, step_in;
   word_type          rem_ff, rem_in;
   word_type          quo_ff, quo_in;
   word_type          mag_b_ff, mag_b_in;
   logic              neg_ff, neg_in;

   logic [DATA_W:0]   trial;
   logic [DATA_W:0]   diff;
   logic              fits;

   // One restoring step: shift in the next dividend bit and try the subtract.
   assign trial = {rem_ff, quo_ff[DATA_W-1]};
   assign diff  = trial - {1'b0, mag_b_ff};
   assign fits  = ~diff[DATA_W];

   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      step_in  = step_ff;
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      mag_b_in = mag_b_ff;
      neg_in   = neg_ff;
      if (start) begin
         // Work on magnitudes and remember the sign of the quotient.
         busy_in  = 1'b1;
         step_in  = STEP_W'(DATA_W);
         rem_in   = '0;
         quo_in   = dividend[DATA_W-1] ? (word_type'(0) - dividend) : dividend;
         mag_b_in = divisor[DATA_W-1] ? (word_type'(0) - divisor) : divisor;
         neg_in   = dividend[DATA_W-1] ^ divisor[DATA_W-1];
      end else if (busy_ff) begin
         rem_in  = fits ? diff[DATA_W-1:0] : trial[DATA_W-1:0];
         quo_in  = {quo_ff[DATA_W-2:0], fits};
         step_in = step_ff - STEP_W'(1);
         if (step_ff == STEP_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      rem_ff   <= rem_in;
      quo_ff   <= quo_in;
      mag_b_ff <= mag_b_in;
      neg_ff   <= neg_in;
   end

   assign done     = done_ff;
   assign quotient = neg_ff ? (word_type'(0) - quo_ff) : quo_ff;

endmodule

### rtl/core/postfix_expression_evaluator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Postfix expression evaluator
// Evaluates a postfix byte stream on a 32-bit value stack held in a RAM.
// ----------------------------------------------------------------------------
// Bytes arrive one request at a time; last marks the final byte, and only that
// byte produces a response (value and status). An operand byte, a parenthesis
// or any byte after an error is handled as it is taken; no further byte is
// taken until the sequencer is back in idle. The operators + - * read both
// operands from the stack RAM one after the other through its single
// registered read port. The operator / waits on the radix-2 divider, which
// produces one quotient bit per cycle. A final byte then reads the bottom entry
// and waits for the response register to be free. The stack needs no clearing
// after reset, so requests are taken from the first cycle out of reset.
// ----------------------------------------------------------------------------
module postfix_expression_evaluator #(
   parameter int STACK_DEPTH = 32
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  pfe_pkg::symbol_type        req_symbol,
   input  logic                       req_last,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic signed [pfe_pkg::DATA_W-1:0] rsp_value,
   output pfe_pkg::status_type        rsp_status
);

   import pfe_pkg::*;

   localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
   localparam int CW = $clog2(STACK_DEPTH + 1);

   localparam logic [2:0] S_IDLE    = 3'd0;
   localparam logic [2:0] S_RD_RHS  = 3'd1;
   localparam logic [2:0] S_RD_LHS  = 3'd2;
   localparam logic [2:0] S_EXEC    = 3'd3;
   localparam logic [2:0] S_DIV     = 3'd4;
   localparam logic [2:0] S_FIN_RD  = 3'd5;
   localparam logic [2:0] S_FIN_OUT = 3'd6;

   logic [2:0]    state_ff, state_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   status_type    err_ff, err_in;
   symbol_type    sym_ff, sym_in;
   logic          last_ff, last_in;
   word_type      rhs_ff, rhs_in;
   logic          rsp_valid_ff, rsp_valid_in;
   word_type      rsp_value_ff, rsp_value_in;
   status_type    rsp_status_ff, rsp_status_in;

   logic          wr_en;
   logic [AW-1:0] wr_addr;
   word_type      wr_data;
   logic          rd_en;
   logic [AW-1:0] rd_addr;
   word_type      rd_data;

   logic          div_start;
   logic          div_done;
   word_type      div_quotient;

   logic          req_fire;
   logic          slot_free;
   logic [CW-1:0] cnt_m1;
   logic [CW-1:0] cnt_m2;
   logic [2:0]    next_after;

   pfe_ram #(
      .WIDTH (DATA_W),
      .DEPTH (STACK_DEPTH)
   ) u_stack (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   pfe_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (rd_data),
      .divisor  (rhs_ff),
      .done     (div_done),
      .quotient (div_quotient)
   );

   assign req_ready = (state_ff == S_IDLE);
   assign req_fire  = req_valid & req_ready;
   assign slot_free = ~rsp_valid_ff | rsp_ready;
   assign cnt_m1    = cnt_ff - CW'(1);
   assign cnt_m2    = cnt_ff - CW'(2);

   // Where to go once the current request is done with the stack.
   assign next_after = last_ff ? S_FIN_RD : S_IDLE;

   // Sequencer: operands are pushed to the stack RAM; operators read-modify-write it.
   // Reads are only issued in states after any write has landed, which keeps
   // every read of an entry behind its last write.
   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      err_in        = err_ff;
      sym_in        = sym_ff;
      last_in       = last_ff;
      rhs_in        = rhs_ff;
      rsp_valid_in  = rsp_valid_ff & ~rsp_ready;
      rsp_value_in  = rsp_value_ff;
      rsp_status_in = rsp_status_ff;
      wr_en         = 1'b0;
      wr_addr       = cnt_m2[AW-1:0];
      wr_data       = '0;
      rd_en         = 1'b0;
      rd_addr       = cnt_m1[AW-1:0];
      div_start     = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               sym_in   = req_symbol;
               last_in  = req_last;
               state_in = req_last ? S_FIN_RD : S_IDLE;
               if (err_ff != ST_OK) begin
                  // An error is latched: the byte is ignored.
               end else if (req_symbol inside {SYM_LPAREN, SYM_RPAREN}) begin
                  err_in = ST_BADCHAR;
               end else if (req_symbol inside {SYM_PLUS, SYM_MINUS, SYM_TIMES,
                                               SYM_DIVIDE}) begin
                  if (cnt_ff < CW'(2)) begin
                     err_in = ST_FEW;
                  end else begin
                     state_in = S_RD_RHS;
                  end
               end else if (cnt_ff >= CW'(STACK_DEPTH)) begin
                  err_in = ST_OVERFLOW;
               end else begin
                  // Operand push: value is the byte less the code of zero.
                  wr_en   = 1'b1;
                  wr_addr = cnt_ff[AW-1:0];
                  wr_data = {{(DATA_W-SYMBOL_W){1'b0}}, req_symbol}
                            - {{(DATA_W-SYMBOL_W){1'b0}}, SYM_ZERO};
                  cnt_in  = cnt_ff + CW'(1);
               end
            end
         end
         S_RD_RHS: begin
            rd_en    = 1'b1;
            rd_addr  = cnt_m1[AW-1:0];
            state_in = S_RD_LHS;
         end
         S_RD_LHS: begin
            rd_en    = 1'b1;
            rd_addr  = cnt_m2[AW-1:0];
            rhs_in   = rd_data;
            state_in = S_EXEC;
         end
         S_EXEC: begin
            // rd_data now holds the left operand.
            state_in = next_after;
            wr_addr  = cnt_m2[AW-1:0];
            case (sym_ff)
               SYM_PLUS: begin
                  wr_en   = 1'b1;
                  wr_data = rd_data + rhs_ff;
                  cnt_in  = cnt_m1;
               end
               SYM_MINUS: begin
                  wr_en   = 1'b1;
                  wr_data = rd_data - rhs_ff;
                  cnt_in  = cnt_m1;
               end
               SYM_TIMES: begin
                  wr_en   = 1'b1;
                  wr_data = rd_data * rhs_ff;
                  cnt_in  = cnt_m1;
               end
               default: begin
                  if (rhs_ff == '0) begin
                     err_in = ST_DIVZERO;
                  end else begin
                     div_start = 1'b1;
                     state_in  = S_DIV;
                  end
               end
            endcase
         end
         S_DIV: begin
            if (div_done) begin
               wr_en    = 1'b1;
               wr_addr  = cnt_m2[AW-1:0];
               wr_data  = div_quotient;
               cnt_in   = cnt_m1;
               state_in = next_after;
            end
         end
         S_FIN_RD: begin
            rd_en    = 1'b1;
            rd_addr  = '0;
            state_in = S_FIN_OUT;
         end
         S_FIN_OUT: begin
            // Form the response once the output register can take it.
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               if (err_ff != ST_OK) begin
                  rsp_value_in  = '0;
                  rsp_status_in = err_ff;
               end else if (cnt_ff == '0) begin
                  rsp_value_in  = '1;
                  rsp_status_in = ST_OK;
               end else if (cnt_ff > CW'(1)) begin
                  rsp_value_in  = '0;
                  rsp_status_in = ST_MANY;
               end else begin
                  rsp_value_in  = rd_data;
                  rsp_status_in = ST_OK;
               end
               cnt_in   = '0;
               err_in   = ST_OK;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         err_ff       <= ST_OK;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         err_ff       <= err_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      sym_ff        <= sym_in;
      last_ff       <= last_in;
      rhs_ff        <= rhs_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_value  = rsp_value_ff;
   assign rsp_status = rsp_status_ff;

   // The stack fill never passes the stack depth.
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CW'(STACK_DEPTH))
      else $error("stack count above depth");

   // An error response always carries a zero value.
   a_err_value: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status == ST_OK || rsp_value == '0))
      else $error("error response with nonzero value");

   // The divider finishes only while the sequencer waits for it.
   a_div_done: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == S_DIV))
      else $error("divider result outside divide wait");

   // A byte after a latched error leaves the stack untouched.
   a_err_skip: assert property (@(posedge clock) disable iff (reset)
      (req_fire && err_ff != ST_OK && !req_last)
         |=> (state_ff == S_IDLE && $stable(cnt_ff)))
      else $error("byte after error changed the stack");

endmodule

### tb/sv/tb_postfix_expression_evaluator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Postfix expression evaluator testbench
// Drives byte streams through the evaluator with random idle gaps on both channels
// and checks every response against an in-bench stack predictor or typed-in row.
// ----------------------------------------------------------------------------
module tb_postfix_expression_evaluator;

   import pfe_pkg::*;

   localparam int STACK_DEPTH  = 32;
   localparam int RANDOM_ITEMS = 650;

   typedef struct {
      word_type   value;
      status_type status;
   } answer_type;

   typedef struct {
      symbol_type sym;
      logic       fin;
      bit         fixed;
      word_type   value;
      status_type status;
   } stim_row_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   symbol_type req_symbol = '0;
   logic       req_last = 1'b0;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic signed [DATA_W-1:0] rsp_value;
   status_type rsp_status;

   // Typed-in expectation that rides along with the request being driven.
   bit         cur_fixed = 1'b0;
   word_type   cur_fixed_value = '0;
   status_type cur_fixed_status = ST_OK;

   // Predictor state.
   word_type   model_stack [STACK_DEPTH];
   int         model_depth = 0;
   status_type model_error = ST_OK;

   answer_type   pending_answers [$];
   stim_row_type directed_rows [$];
   symbol_type   expr_bytes [$];
   int           mismatch_count = 0;
   int           items_sent = 0;
   bit           quiet_tx = 1'b0;
   bit           quiet_rx = 1'b0;

   postfix_expression_evaluator #(
      .STACK_DEPTH(STACK_DEPTH)
   ) u_top (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_symbol (req_symbol),
      .req_last   (req_last),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_value  (rsp_value),
      .rsp_status (rsp_status)
   );

   always #2 clock = ~clock;

   // Hang guard.
   initial begin
      #2_000_000;
      $display("end of test: mismatches");
      $finish;
   end

   function automatic bit is_operator(input symbol_type s);
      return s == SYM_PLUS || s == SYM_MINUS || s == SYM_TIMES || s == SYM_DIVIDE;
   endfunction

   // Signed division that truncates toward zero; the most negative value over
   // minus one wraps back to itself.
   function automatic word_type quotient_toward_zero(input word_type a, input word_type b);
      word_type ma;
      word_type mb;
      word_type q;
      ma = a[DATA_W-1] ? -a : a;
      mb = b[DATA_W-1] ? -b : b;
      q  = ma / mb;
      return (a[DATA_W-1] != b[DATA_W-1]) ? -q : q;
   endfunction

   // Advances the predicted stack by one byte; returns 1 when a response is due.
   function automatic bit predict_symbol(input symbol_type sym, input logic fin,
                                         output answer_type ans);
      word_type lhs;
      word_type rhs;
      word_type res;
      bit       div_zero;
      div_zero = 1'b0;
      res = '0;
      if (model_error == ST_OK) begin
         if (sym == SYM_LPAREN || sym == SYM_RPAREN) begin
            model_error = ST_BADCHAR;
         end else if (is_operator(sym)) begin
            if (model_depth < 2) begin
               model_error = ST_FEW;
            end else begin
               rhs = model_stack[model_depth-1];
               lhs = model_stack[model_depth-2];
               case (sym)
                  SYM_PLUS:  res = lhs + rhs;
                  SYM_MINUS: res = lhs - rhs;
                  SYM_TIMES: res = lhs * rhs;
                  default: begin
                     if (rhs == '0) begin
                        div_zero = 1'b1;
                        model_error = ST_DIVZERO;
                     end else begin
                        res = quotient_toward_zero(lhs, rhs);
                     end
                  end
               endcase
               if (!div_zero) begin
                  model_depth = model_depth - 1;
                  model_stack[model_depth-1] = res;
               end
            end
         end else if (model_depth >= STACK_DEPTH) begin
            model_error = ST_OVERFLOW;
         end else begin
            model_stack[model_depth] = word_type'(sym) - word_type'(SYM_ZERO);
            model_depth = model_depth + 1;
         end
      end
      ans.value  = '0;
      ans.status = model_error;
      if (!fin) return 1'b0;
      if (model_error == ST_OK) begin
         if (model_depth == 0) ans.value = '1;
         else if (model_depth > 1) ans.status = ST_MANY;
         else ans.value = model_stack[0];
      end
      model_depth = 0;
      model_error = ST_OK;
      return 1'b1;
   endfunction

   task automatic note_mismatch(input string what);
      mismatch_count++;
      if (mismatch_count <= 10) $display("%s", what);
   endtask

   // Check responses first, then predict from the request taken at this edge.
   always @(posedge clock) begin : monitor
      answer_type oldest;
      answer_type fresh;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (pending_answers.size() == 0) begin
               note_mismatch($sformatf("unexpected response: value %0d status %0d",
                                       rsp_value, rsp_status));
            end else begin
               oldest = pending_answers.pop_front();
               if (rsp_value !== oldest.value || rsp_status !== oldest.status)
                  note_mismatch($sformatf(
                     "response mismatch: expected value %0d status %0d, got value %0d status %0d",
                     $signed(oldest.value), oldest.status, rsp_value, rsp_status));
            end
         end
         if (req_valid && req_ready) begin
            if (predict_symbol(req_symbol, req_last, fresh)) begin
               if (cur_fixed) begin
                  fresh.value  = cur_fixed_value;
                  fresh.status = cur_fixed_status;
               end
               pending_answers.push_back(fresh);
            end
         end
      end
   end

   // Response side: each response is held off for a drawn number of cycles.
   initial begin : response_sink
      int hold;
      @(negedge reset);
      forever begin
         if ($urandom_range(0, 39) == 0) quiet_rx = ~quiet_rx;
         hold = quiet_rx ? 0 : $urandom_range(0, 15);
         @(negedge clock);
         if (hold == 0) begin
            rsp_ready <= 1'b1;
         end else begin
            rsp_ready <= 1'b0;
            do @(posedge clock); while (!rsp_valid);
            repeat (hold - 1) @(posedge clock);
            @(negedge clock);
            rsp_ready <= 1'b1;
         end
         do @(posedge clock); while (!rsp_valid);
      end
   end

   // Presents one request after a drawn gap and waits for it to be taken.
   task automatic send_symbol(input symbol_type sym, input logic fin, input bit fixed,
                              input word_type fval, input status_type fst);
      int gap;
      if ($urandom_range(0, 39) == 0) quiet_tx = ~quiet_tx;
      gap = quiet_tx ? 0 : $urandom_range(0, 15);
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_symbol       <= sym;
      req_last         <= fin;
      cur_fixed        <= fixed;
      cur_fixed_value  <= fval;
      cur_fixed_status <= fst;
      req_valid        <= 1'b1;
      do @(posedge clock); while (!req_ready);
      items_sent++;
   endtask

   task automatic add_row(input symbol_type sym, input logic fin, input bit fixed,
                          input word_type fval, input status_type fst);
      stim_row_type row;
      row.sym    = sym;
      row.fin    = fin;
      row.fixed  = fixed;
      row.value  = fval;
      row.status = fst;
      directed_rows.push_back(row);
   endtask

   function automatic symbol_type random_operand();
      symbol_type s;
      if ($urandom_range(0, 9) < 6) return SYM_ZERO + symbol_type'($urandom_range(0, 9));
      do s = symbol_type'($urandom_range(0, 255));
      while (is_operator(s) || s == SYM_LPAREN || s == SYM_RPAREN);
      return s;
   endfunction

   function automatic symbol_type random_operator();
      case ($urandom_range(0, 3))
         0:       return SYM_PLUS;
         1:       return SYM_MINUS;
         2:       return SYM_TIMES;
         default: return SYM_DIVIDE;
      endcase
   endfunction

   // Builds a well-formed expression whose stack peaks at the target depth.
   task automatic build_well_formed(input int target);
      int depth;
      int extra;
      depth = 0;
      extra = $urandom_range(0, 3);
      expr_bytes.delete();
      while (depth < target) begin
         if (depth >= 2 && extra > 0 && $urandom_range(0, 1) == 1) begin
            expr_bytes.push_back(random_operator());
            depth--;
            extra--;
         end else begin
            expr_bytes.push_back(random_operand());
            depth++;
         end
      end
      while (depth > 1) begin
         expr_bytes.push_back(random_operator());
         depth--;
      end
   endtask

   initial begin : stimulus
      int kind;
      int pos;
      int n;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed rows: single operands at the byte extremes, each error kind but
      // overflow, and the most negative value divided by minus one.
      add_row(SYM_ZERO, 1'b1, 1'b1, 32'd0, ST_OK);
      add_row(8'h00, 1'b1, 1'b1, -32'sd48, ST_OK);
      add_row(8'hFF, 1'b1, 1'b1, 32'd207, ST_OK);
      add_row(SYM_ZERO + 8'd5, 1'b0, 1'b0, '0, ST_OK);
      add_row(SYM_PLUS, 1'b1, 1'b1, 32'd0, ST_FEW);
      add_row(SYM_ZERO + 8'd9, 1'b0, 1'b0, '0, ST_OK);
      add_row(SYM_ZERO, 1'b0, 1'b0, '0, ST_OK);
      add_row(SYM_DIVIDE, 1'b1, 1'b1, 32'd0, ST_DIVZERO);
      add_row(SYM_LPAREN, 1'b1, 1'b1, 32'd0, ST_BADCHAR);
      add_row(SYM_RPAREN, 1'b1, 1'b1, 32'd0, ST_BADCHAR);
      add_row(SYM_ZERO + 8'd1, 1'b0, 1'b0, '0, ST_OK);
      add_row(SYM_ZERO + 8'd2, 1'b1, 1'b1, 32'd0, ST_MANY);
      // 128^4 * 8 reaches the most negative word.
      add_row(8'hB0, 1'b0, 1'b0, '0, ST_OK);
      add_row(8'hB0, 1'b0, 1'b0, '0, ST_OK);
      add_row(SYM_TIMES, 1'b0, 1'b0, '0, ST_OK);
      add_row(8'hB0, 1'b0, 1'b0, '0, ST_OK);
      add_row(SYM_TIMES, 1'b0, 1'b0, '0, ST_OK);
      add_row(8'hB0, 1'b0, 1'b0, '0, ST_OK);
      add_row(SYM_TIMES, 1'b0, 1'b0, '0, ST_OK);
      add_row(SYM_ZERO + 8'd8, 1'b0, 1'b0, '0, ST_OK);
      add_row(SYM_TIMES, 1'b0, 1'b0, '0, ST_OK);
      add_row(SYM_ZERO, 1'b0, 1'b0, '0, ST_OK);
      add_row(SYM_ZERO + 8'd1, 1'b0, 1'b0, '0, ST_OK);
      add_row(SYM_MINUS, 1'b0, 1'b0, '0, ST_OK);
      add_row(SYM_DIVIDE, 1'b1, 1'b1, 32'h8000_0000, ST_OK);

      foreach (directed_rows[i])
         send_symbol(directed_rows[i].sym, directed_rows[i].fin, directed_rows[i].fixed,
                     directed_rows[i].value, directed_rows[i].status);

      // Random expressions: mostly well-formed, some broken, some that overrun
      // the stack, and some raw byte noise.
      items_sent = 0;
      while (items_sent < RANDOM_ITEMS) begin
         kind = $urandom_range(0, 99);
         if (kind < 80) begin
            build_well_formed(($urandom_range(0, 9) == 0) ? STACK_DEPTH
                                                          : $urandom_range(1, 4));
            if (kind >= 70) begin
               if (expr_bytes.size() > 1 && $urandom_range(0, 1) == 1) begin
                  n = $urandom_range(1, expr_bytes.size() - 1);
                  while (expr_bytes.size() > n) void'(expr_bytes.pop_back());
               end else begin
                  pos = $urandom_range(0, expr_bytes.size() - 1);
                  if ($urandom_range(0, 1) == 1)
                     expr_bytes[pos] = ($urandom_range(0, 1) == 1) ? SYM_LPAREN : SYM_RPAREN;
                  else
                     expr_bytes[pos] = symbol_type'($urandom_range(0, 255));
               end
            end
         end else if (kind < 84) begin
            expr_bytes.delete();
            repeat (STACK_DEPTH + $urandom_range(1, 3)) expr_bytes.push_back(random_operand());
         end else begin
            expr_bytes.delete();
            repeat ($urandom_range(1, 8))
               expr_bytes.push_back(symbol_type'($urandom_range(0, 255)));
         end
         foreach (expr_bytes[i])
            send_symbol(expr_bytes[i], i == expr_bytes.size() - 1, 1'b0, '0, ST_OK);
      end

      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_answers.size() != 0) @(posedge clock);
      repeat (64) @(posedge clock);

      if (mismatch_count == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule

### sim.f
rtl/core/pfe_pkg.sv
rtl/core/pfe_ram.sv
rtl/core/pfe_div.sv
rtl/core/postfix_expression_evaluator.sv
tb/sv/tb_postfix_expression_evaluator.sv
